@@ rtl/lkvc_pkg.sv @@
// Package for the LRU key/value cache: payload structs, cell entry and control
// types, and sizing constants. No dependencies; used by every rtl file.
package lkvc_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 31;
  localparam int CAP_BITS   = 5;
  localparam int OCC_BITS   = $clog2(CAPACITY + 1);
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 3;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(CAPACITY);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                  command;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
  } rsp_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                capture;
    logic [KEY_BITS-1:0] key;
    logic                update;
    logic                hit;
    logic                put;
    logic                evict;
  } cell_ctrl_t;

endpackage

@@ rtl/lkvc_cell.sv @@
// One recency slot of the LRU chain: holds an entry, registers its key match,
// and takes its upper neighbor's entry on a shift. Depends on lkvc_pkg.
module lkvc_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  lkvc_pkg::cell_ctrl_t           ctrl,
  input  lkvc_pkg::entry_t               prev,
  output lkvc_pkg::entry_t               entry,
  input  logic                           tail_in,
  output logic                           tail_out,
  input  logic [lkvc_pkg::VALUE_BITS-1:0] hitval_in,
  output logic [lkvc_pkg::VALUE_BITS-1:0] hitval_out
);

  logic match;
  logic shift;

  assign tail_out   = tail_in | match;
  assign hitval_out = hitval_in | (match ? entry.value : '0);

  always_comb begin
    if (ctrl.hit) begin
      shift = tail_out;
    end else if (ctrl.put) begin
      shift = ctrl.evict ? entry.valid : prev.valid;
    end else begin
      shift = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      match       <= 1'b0;
    end else begin
      if (ctrl.update && shift) begin
        entry <= prev;
      end
      if (ctrl.capture) begin
        match <= entry.valid && (entry.key == ctrl.key);
      end
    end
  end

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
// LRU key/value cache top: chain of recency cells, control, response register
// and APB capacity register. Depends on lkvc_pkg and lkvc_cell.
// An accepted request is registered with its key match; the response register
// loads on the chain shift, and no request is taken until that shift is done.
// A stalled response holds the next update; the request side stalls meanwhile.
// Reset: all entries invalid, capacity 16, no clearing pass; ready at once.
module lru_key_value_cache_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  lkvc_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output lkvc_pkg::rsp_t                      rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkvc_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [lkvc_pkg::DATA_BITS-1:0]      pwdata,
  output logic [lkvc_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  logic                                busy;
  lkvc_pkg::req_t                      item;
  logic [lkvc_pkg::CAP_BITS-1:0]       capacity;
  logic [lkvc_pkg::OCC_BITS-1:0]       occ;
  logic [lkvc_pkg::CAP_BITS-1:0]       eff_cap;
  logic                                accept;
  logic                                do_update;
  logic                                full;
  logic [lkvc_pkg::VALUE_BITS-1:0]     hit_value;
  lkvc_pkg::cell_ctrl_t                ctrl;
  lkvc_pkg::entry_t                    front;
  lkvc_pkg::entry_t                    entries [lkvc_pkg::CAPACITY];
  lkvc_pkg::entry_t                    prevs   [lkvc_pkg::CAPACITY];
  logic                                tails   [lkvc_pkg::CAPACITY+1];
  logic [lkvc_pkg::VALUE_BITS-1:0]     hvals   [lkvc_pkg::CAPACITY+1];

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == lkvc_pkg::REG_CAPACITY)
                     ? lkvc_pkg::DATA_BITS'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == lkvc_pkg::REG_CAPACITY) begin
      capacity <= pwdata[lkvc_pkg::CAP_BITS-1:0];
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = lkvc_pkg::CAP_BITS'(1);
    end else if (capacity > lkvc_pkg::CAP_BITS'(lkvc_pkg::CAPACITY)) begin
      eff_cap = lkvc_pkg::CAP_BITS'(lkvc_pkg::CAPACITY);
    end else begin
      eff_cap = capacity;
    end
  end

  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  assign do_update = busy && (!rsp_valid || !rsp_stall);
  assign full      = lkvc_pkg::CAP_BITS'(occ) >= eff_cap;
  assign hit_value = hvals[lkvc_pkg::CAPACITY];

  always_comb begin
    ctrl.capture = accept;
    ctrl.key     = req.lookup_key;
    ctrl.update  = do_update;
    ctrl.hit     = tails[0];
    ctrl.put     = item.command == lkvc_pkg::CMD_PUT;
    ctrl.evict   = ctrl.put && !ctrl.hit && full;
  end

  always_comb begin
    front.valid = 1'b1;
    front.key   = item.lookup_key;
    front.value = ctrl.put ? item.write_value : hit_value;
  end

  assign tails[lkvc_pkg::CAPACITY] = 1'b0;
  assign hvals[0]                  = '0;

  for (genvar i = 0; i < lkvc_pkg::CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prevs[i] = front;
    end else begin : g_body
      assign prevs[i] = entries[i-1];
    end

    lkvc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev       (prevs[i]),
      .entry      (entries[i]),
      .tail_in    (tails[i+1]),
      .tail_out   (tails[i]),
      .hitval_in  (hvals[i]),
      .hitval_out (hvals[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      occ       <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (do_update) begin
        busy <= 1'b0;
      end
      if (do_update) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (do_update && ctrl.put && !ctrl.hit && !full) begin
        occ <= occ + lkvc_pkg::OCC_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      rsp.hit        <= ctrl.hit;
      rsp.read_value <= (ctrl.hit && !ctrl.put) ? hit_value : '0;
      rsp.evicted    <= ctrl.evict;
    end
  end

endmodule

@@ rtl/lkvc_checker.sv @@
// Port-level checks for the LRU key/value cache core, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_core.
module lkvc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input lkvc_pkg::rsp_t rsp
);

  a_no_rsp_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous transaction in flight");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.evicted))
    else $error("eviction reported on a hit");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.read_value != '0) |-> rsp.hit)
    else $error("read value returned without a hit");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);
